[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Each macro has a checking form and an empty form for synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

[rtl/mvid_pkg.sv]
`default_nettype none

package mvid_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Attribute counts
  localparam int MAX_ATTRIBUTES = 1048576;
  localparam int ATTR_CNT_W     = $clog2(MAX_ATTRIBUTES + 1);

  // Field widths
  localparam int IN_IDX_W = 21;
  localparam int ZB_W     = 20;
  localparam int KEY_W    = 3 * ZB_W;

  // Command codes
  localparam logic [1:0] CMD_POS  = 2'd0;
  localparam logic [1:0] CMD_TEX  = 2'd1;
  localparam logic [1:0] CMD_NORM = 2'd2;
  localparam logic [1:0] CMD_FACE = 2'd3;

  // Locked face form codes
  localparam logic [2:0] FORM_NONE = 3'd0;
  localparam logic [2:0] FORM_V    = 3'd1;
  localparam logic [2:0] FORM_VT   = 3'd2;
  localparam logic [2:0] FORM_VN   = 3'd3;
  localparam logic [2:0] FORM_VTN  = 3'd4;

  // Status codes
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_MISMATCH = 3'd1;
  localparam logic [2:0] STATUS_RANGE    = 3'd2;
  localparam logic [2:0] STATUS_FULL     = 3'd3;
  localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

  typedef logic [KEY_W-1:0] mvid_key_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
  } mvid_tok_t;

endpackage

`default_nettype wire

[rtl/mvid_cell.sv]
`default_nettype none

module mvid_cell import mvid_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire logic [CNT_W-1:0] seen_count_i,
  input  wire mvid_key_t        key_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire mvid_tok_t        tok_i,
  output mvid_tok_t             tok_o
);

  mvid_key_t entry_q;
  logic      tok_valid_q;
  logic      tok_found_q;
  logic [IDX_W-1:0] tok_idx_q;

  logic live;
  logic match;

  // Only entries below the fill count hold a written triple
  assign live  = {1'b0, cell_idx_i} < seen_count_i;
  assign match = tok_i.valid && !tok_i.found && live && (entry_q == key_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == cell_idx_i)) begin
      entry_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  // Keep the first hit; later cells pass it on
  always_ff @(posedge clk_i) begin
    tok_found_q <= tok_i.found || match;
    tok_idx_q   <= match ? cell_idx_i : tok_i.idx;
  end

  assign tok_o.valid = tok_valid_q;
  assign tok_o.found = tok_found_q;
  assign tok_o.idx   = tok_idx_q;

endmodule

`default_nettype wire

[rtl/mesh_vertex_index_dedup.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------------------
// in       | in_valid_i / in_stall_o | cmd_i, corner_form_i, pos/tex/norm_index_i
// out      | out_valid_o / out_stall_i | status_o, vertex_out_index_o, is_new_vertex_o,
//          |                        | pos/tex/norm_zero_based_o, face_form_o
//
// A declaration beat is captured, then evaluated. A face corner that passes
// its checks sends a search token along the row of TABLE_DEPTH table cells,
// one cell per cycle, and is answered once the token leaves the last cell.
// Corners refused by the form or index checks are answered without a search.
// Reset clears the counts, the locked form, the fill count and the token line;
// table entries stay unwritten until a miss appends to them.
// A stalled output holds its beat; the next input beat is still taken meanwhile.
`default_nettype none
`include "assert_macros.svh"

module mesh_vertex_index_dedup import mvid_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          cmd_i,
  input  wire logic [1:0]          corner_form_i,
  input  wire logic [IN_IDX_W-1:0] pos_index_i,
  input  wire logic [IN_IDX_W-1:0] tex_index_i,
  input  wire logic [IN_IDX_W-1:0] norm_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [2:0]               status_o,
  output logic [IDX_W-1:0]         vertex_out_index_o,
  output logic                     is_new_vertex_o,
  output logic [ZB_W-1:0]          pos_zero_based_o,
  output logic [ZB_W-1:0]          tex_zero_based_o,
  output logic [ZB_W-1:0]          norm_zero_based_o,
  output logic [2:0]               face_form_o
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  // Captured input beat
  logic [1:0]          cmd_q;
  logic [1:0]          corner_form_q;
  logic [IN_IDX_W-1:0] pi_q, ti_q, ni_q;

  // Mesh state
  logic [2:0]            locked_q, locked_d;
  logic [ATTR_CNT_W-1:0] pos_cnt_q, pos_cnt_d;
  logic [ATTR_CNT_W-1:0] tex_cnt_q, tex_cnt_d;
  logic [ATTR_CNT_W-1:0] norm_cnt_q, norm_cnt_d;
  logic [CNT_W-1:0]      seen_count_q, seen_count_d;

  // Search key and captured search result
  mvid_key_t        key_q, key_d;
  logic             found_q;
  logic [IDX_W-1:0] hit_idx_q;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [2:0]       status_q;
  logic [IDX_W-1:0] vidx_q;
  logic             is_new_q;
  logic [ZB_W-1:0]  p_out_q, t_out_q, n_out_q;
  logic [2:0]       form_out_q;

  // Evaluation of the captured beat
  logic [2:0]            form_in;
  logic                  mismatch;
  logic [2:0]            lock_next;
  logic                  has_t, has_n;
  logic                  bad_p, bad_t, bad_n, bad_idx;
  logic [ATTR_CNT_W-1:0] decl_cnt;
  logic                  overflow;
  logic [ZB_W-1:0]       p_zb, t_zb, n_zb;
  logic                  out_free;
  logic                  table_full;
  logic                  start_search;
  logic                  append;

  // Result being written into the output register
  logic             emit;
  logic [2:0]       e_status;
  logic [IDX_W-1:0] e_idx;
  logic             e_new;
  logic             e_ok;
  logic [2:0]       e_form;

  // Token line through the cells
  mvid_tok_t tok [TABLE_DEPTH+1];
  mvid_tok_t tok_out;

  assign form_in   = {1'b0, corner_form_q} + 3'd1;
  assign mismatch  = (locked_q != FORM_NONE) && (locked_q != form_in);
  assign lock_next = (locked_q == FORM_NONE) ? form_in : locked_q;
  assign has_t     = (form_in == FORM_VT) || (form_in == FORM_VTN);
  assign has_n     = (form_in == FORM_VN) || (form_in == FORM_VTN);

  assign bad_p   = (pi_q == '0) || (32'(pi_q) > 32'(pos_cnt_q));
  assign bad_t   = has_t && ((ti_q == '0) || (32'(ti_q) > 32'(tex_cnt_q)));
  assign bad_n   = has_n && ((ni_q == '0) || (32'(ni_q) > 32'(norm_cnt_q)));
  assign bad_idx = bad_p || bad_t || bad_n;

  // Unused components go to zero in the key and the result
  assign p_zb = ZB_W'(pi_q - IN_IDX_W'(1));
  assign t_zb = has_t ? ZB_W'(ti_q - IN_IDX_W'(1)) : '0;
  assign n_zb = has_n ? ZB_W'(ni_q - IN_IDX_W'(1)) : '0;

  always_comb begin
    case (cmd_q)
      CMD_POS:  decl_cnt = pos_cnt_q;
      CMD_TEX:  decl_cnt = tex_cnt_q;
      CMD_NORM: decl_cnt = norm_cnt_q;
      default:  decl_cnt = '0;
    endcase
  end

  assign overflow   = decl_cnt >= ATTR_CNT_W'(MAX_ATTRIBUTES);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign table_full = seen_count_q == CNT_W'(TABLE_DEPTH);
  assign start_search = (state_q == ST_EVAL) && (cmd_q == CMD_FACE) && !mismatch && !bad_idx;
  assign append = (state_q == ST_FINISH) && out_free && !found_q && !table_full;

  // Sequencer: commit each beat's state change exactly once
  always_comb begin
    state_d      = state_q;
    locked_d     = locked_q;
    pos_cnt_d    = pos_cnt_q;
    tex_cnt_d    = tex_cnt_q;
    norm_cnt_d   = norm_cnt_q;
    seen_count_d = seen_count_q;
    key_d        = key_q;
    emit         = 1'b0;
    e_status     = STATUS_OK;
    e_idx        = '0;
    e_new        = 1'b0;
    e_ok         = 1'b0;
    e_form       = locked_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (cmd_q != CMD_FACE) begin
          if (overflow) begin
            // Hold until the output register frees up
            if (out_free) begin
              emit     = 1'b1;
              e_status = STATUS_OVERFLOW;
              state_d  = ST_IDLE;
            end
          end else begin
            case (cmd_q)
              CMD_POS:  pos_cnt_d  = pos_cnt_q + 1'b1;
              CMD_TEX:  tex_cnt_d  = tex_cnt_q + 1'b1;
              default:  norm_cnt_d = norm_cnt_q + 1'b1;
            endcase
            state_d = ST_IDLE;
          end
        end else if (mismatch) begin
          if (out_free) begin
            emit     = 1'b1;
            e_status = STATUS_MISMATCH;
            state_d  = ST_IDLE;
          end
        end else begin
          // Lock the form even if the index check fails
          locked_d = lock_next;
          if (bad_idx) begin
            if (out_free) begin
              emit     = 1'b1;
              e_status = STATUS_RANGE;
              e_form   = lock_next;
              state_d  = ST_IDLE;
            end
          end else begin
            key_d   = {n_zb, t_zb, p_zb};
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (tok_out.valid) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (found_q) begin
            e_idx = hit_idx_q;
            e_ok  = 1'b1;
          end else if (table_full) begin
            e_status = STATUS_FULL;
          end else begin
            e_idx        = seen_count_q[IDX_W-1:0];
            e_new        = 1'b1;
            e_ok         = 1'b1;
            seen_count_d = seen_count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      locked_q     <= FORM_NONE;
      pos_cnt_q    <= '0;
      tex_cnt_q    <= '0;
      norm_cnt_q   <= '0;
      seen_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      locked_q     <= locked_d;
      pos_cnt_q    <= pos_cnt_d;
      tex_cnt_q    <= tex_cnt_d;
      norm_cnt_q   <= norm_cnt_d;
      seen_count_q <= seen_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: capture on accept, search result, emitted beat
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      cmd_q         <= cmd_i;
      corner_form_q <= corner_form_i;
      pi_q          <= pos_index_i;
      ti_q          <= tex_index_i;
      ni_q          <= norm_index_i;
    end
    key_q <= key_d;
    if (tok_out.valid) begin
      found_q   <= tok_out.found;
      hit_idx_q <= tok_out.idx;
    end
    if (emit) begin
      status_q   <= e_status;
      vidx_q     <= e_idx;
      is_new_q   <= e_new;
      p_out_q    <= e_ok ? key_q[ZB_W-1:0] : '0;
      t_out_q    <= e_ok ? key_q[2*ZB_W-1:ZB_W] : '0;
      n_out_q    <= e_ok ? key_q[3*ZB_W-1:2*ZB_W] : '0;
      form_out_q <= e_form;
    end
  end

  // Inject the search token into the first cell; it leaves the last one
  assign tok[0].valid = start_search;
  assign tok[0].found = 1'b0;
  assign tok[0].idx   = '0;

  // The first cell compares in the cycle the token is injected, so give the
  // row the key that is being set up in that same cycle
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    mvid_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (IDX_W'(k)),
      .seen_count_i (seen_count_q),
      .key_i        (key_d),
      .wr_en_i      (append),
      .wr_idx_i     (seen_count_q[IDX_W-1:0]),
      .tok_i        (tok[k]),
      .tok_o        (tok[k+1])
    );
  end

  assign tok_out = tok[TABLE_DEPTH];

  assign in_stall_o         = state_q != ST_IDLE;
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign vertex_out_index_o = vidx_q;
  assign is_new_vertex_o    = is_new_q;
  assign pos_zero_based_o   = p_out_q;
  assign tex_zero_based_o   = t_out_q;
  assign norm_zero_based_o  = n_out_q;
  assign face_form_o        = form_out_q;

  `ASSERT_NEVER(a_seen_bound, clk_i, rst_ni, seen_count_q > CNT_W'(TABLE_DEPTH))
  `ASSERT_PROP(a_tok_in_search, clk_i, rst_ni, tok_out.valid |-> state_q == ST_SEARCH)
  `ASSERT_PROP(a_new_is_ok, clk_i, rst_ni, (out_valid_q && is_new_q) |-> status_q == STATUS_OK)
  `ASSERT_PROP(a_append_step, clk_i, rst_ni, append |=> seen_count_q == $past(seen_count_q) + 1'b1)

endmodule

`default_nettype wire

[tb/sv/tb_mesh_vertex_index_dedup.sv]
module tb_mesh_vertex_index_dedup;
  import mvid_pkg::*;

  // Corner form codes as they travel on corner_form_i (locked form is code + 1)
  localparam logic [1:0] CORNER_V   = 2'd0;
  localparam logic [1:0] CORNER_VT  = 2'd1;
  localparam logic [1:0] CORNER_VN  = 2'd2;
  localparam logic [1:0] CORNER_VTN = 2'd3;

  localparam int unsigned RANDOM_BEATS = 400;
  // A corner that reaches the table walks every cell before it answers
  localparam int unsigned SEARCH_CYCLES = TABLE_DEPTH + 3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [1:0]          corner;
    logic [IN_IDX_W-1:0] pos;
    logic [IN_IDX_W-1:0] tex;
    logic [IN_IDX_W-1:0] norm;
  } dedup_beat_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] vtx_idx;
    logic             is_new;
    logic [ZB_W-1:0]  pos;
    logic [ZB_W-1:0]  tex;
    logic [ZB_W-1:0]  norm;
    logic [2:0]       face_form;
  } dedup_result_t;

  // Tracks counts, locked form and the table of seen triples, and holds the
  // results still owed by the block, oldest first.
  class dedup_scoreboard;
    logic [2:0]            locked_form;
    logic [ATTR_CNT_W-1:0] attr_count [3];
    mvid_key_t             seen_keys [TABLE_DEPTH];
    int unsigned           seen_count;
    dedup_result_t         awaited_results [$];
    int unsigned           mismatch_count;
    int unsigned           status_tally [5];
    int unsigned           new_vertices;

    function new();
      locked_form = FORM_NONE;
      foreach (attr_count[k]) attr_count[k] = '0;
      foreach (status_tally[k]) status_tally[k] = 0;
      seen_count     = 0;
      mismatch_count = 0;
      new_vertices   = 0;
    endfunction

    static function logic in_range(logic [IN_IDX_W-1:0] idx, logic [ATTR_CNT_W-1:0] count);
      return (idx != '0) && (idx <= count);
    endfunction

    function void note_beat(dedup_beat_t b);
      dedup_result_t   r;
      logic [2:0]      form;
      logic            has_tex;
      logic            has_norm;
      logic [ZB_W-1:0] p;
      logic [ZB_W-1:0] t;
      logic [ZB_W-1:0] n;
      mvid_key_t       key;
      int              slot;
      int              k;
      r = '0;
      t = '0;
      n = '0;
      // Declarations only count; a full count answers with overflow
      if (b.cmd != CMD_FACE) begin
        if (attr_count[b.cmd] < MAX_ATTRIBUTES) begin
          attr_count[b.cmd]++;
        end else begin
          r.status    = STATUS_OVERFLOW;
          r.face_form = locked_form;
          awaited_results.push_back(r);
        end
        return;
      end
      // Lock on the first corner, even if that corner fails later on
      form = {1'b0, b.corner} + 3'd1;
      if (locked_form == FORM_NONE) locked_form = form;
      r.face_form = locked_form;
      if (locked_form != form) begin
        r.status = STATUS_MISMATCH;
        awaited_results.push_back(r);
        return;
      end
      has_tex  = (form == FORM_VT) || (form == FORM_VTN);
      has_norm = (form == FORM_VN) || (form == FORM_VTN);
      if (!in_range(b.pos, attr_count[CMD_POS]) ||
          (has_tex && !in_range(b.tex, attr_count[CMD_TEX])) ||
          (has_norm && !in_range(b.norm, attr_count[CMD_NORM]))) begin
        r.status = STATUS_RANGE;
        awaited_results.push_back(r);
        return;
      end
      // Unused components stay zero in the key and in the result
      p = ZB_W'(b.pos - 1'b1);
      if (has_tex) t = ZB_W'(b.tex - 1'b1);
      if (has_norm) n = ZB_W'(b.norm - 1'b1);
      key  = {n, t, p};
      slot = -1;
      for (k = 0; k < int'(seen_count) && slot < 0; k++) begin
        if (seen_keys[k] == key) slot = k;
      end
      if (slot < 0) begin
        if (seen_count >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
          awaited_results.push_back(r);
          return;
        end
        slot = seen_count;
        seen_keys[slot] = key;
        seen_count++;
        r.is_new = 1'b1;
      end
      r.status  = STATUS_OK;
      r.vtx_idx = IDX_W'(slot);
      r.pos     = p;
      r.tex     = t;
      r.norm    = n;
      awaited_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_result(dedup_result_t got);
      dedup_result_t want;
      string         diff;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d index %0d",
                                  got.status, got.vtx_idx));
        return;
      end
      want = awaited_results.pop_front();
      diff = "";
      if (got.status != want.status)
        diff = {diff, $sformatf(" status %0d/%0d", got.status, want.status)};
      if (got.vtx_idx != want.vtx_idx)
        diff = {diff, $sformatf(" index %0d/%0d", got.vtx_idx, want.vtx_idx)};
      if (got.is_new != want.is_new)
        diff = {diff, $sformatf(" new %0b/%0b", got.is_new, want.is_new)};
      if (got.pos != want.pos)
        diff = {diff, $sformatf(" pos %0d/%0d", got.pos, want.pos)};
      if (got.tex != want.tex)
        diff = {diff, $sformatf(" tex %0d/%0d", got.tex, want.tex)};
      if (got.norm != want.norm)
        diff = {diff, $sformatf(" norm %0d/%0d", got.norm, want.norm)};
      if (got.face_form != want.face_form)
        diff = {diff, $sformatf(" form %0d/%0d", got.face_form, want.face_form)};
      if (diff != "") report_mismatch({"got/expected:", diff});
      status_tally[want.status]++;
      if (want.is_new) new_vertices++;
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          cmd_i;
  logic [1:0]          corner_form_i;
  logic [IN_IDX_W-1:0] pos_index_i;
  logic [IN_IDX_W-1:0] tex_index_i;
  logic [IN_IDX_W-1:0] norm_index_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [2:0]          status_o;
  logic [IDX_W-1:0]    vertex_out_index_o;
  logic                is_new_vertex_o;
  logic [ZB_W-1:0]     pos_zero_based_o;
  logic [ZB_W-1:0]     tex_zero_based_o;
  logic [ZB_W-1:0]     norm_zero_based_o;
  logic [2:0]          face_form_o;

  dedup_scoreboard sb;
  // Declarations sent so far, per attribute kind, saturating like the block
  int unsigned     declared [3];
  // The one form this mesh locks to; other forms only ever get refused
  logic [1:0]      mesh_corner;

  mesh_vertex_index_dedup DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .corner_form_i      (corner_form_i),
    .pos_index_i        (pos_index_i),
    .tex_index_i        (tex_index_i),
    .norm_index_i       (norm_index_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .vertex_out_index_o (vertex_out_index_o),
    .is_new_vertex_o    (is_new_vertex_o),
    .pos_zero_based_o   (pos_zero_based_o),
    .tex_zero_based_o   (tex_zero_based_o),
    .norm_zero_based_o  (norm_zero_based_o),
    .face_form_o        (face_form_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watch both channels at the rising edge. Check the output beat before
  // noting the input beat: no result can belong to a beat taken this edge.
  always @(posedge clk_i) begin : port_watch
    dedup_result_t got;
    dedup_beat_t   taken;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.status    = status_o;
        got.vtx_idx   = vertex_out_index_o;
        got.is_new    = is_new_vertex_o;
        got.pos       = pos_zero_based_o;
        got.tex       = tex_zero_based_o;
        got.norm      = norm_zero_based_o;
        got.face_form = face_form_o;
        sb.check_result(got);
      end
      if (in_valid_i && !in_stall_o) begin
        taken.cmd    = cmd_i;
        taken.corner = corner_form_i;
        taken.pos    = pos_index_i;
        taken.tex    = tex_index_i;
        taken.norm   = norm_index_i;
        sb.note_beat(taken);
      end
    end
  end

  // Output backpressure: open stretches of random length, then a stall of
  // random length that is now and then a long one.
  initial begin
    int unsigned open_run;
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      open_run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                             : $urandom_range(0, 30);
      hold     = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                             : $urandom_range(1, 3);
      repeat (open_run) @(negedge clk_i);
      @(negedge clk_i) out_stall_i <= 1'b1;
      repeat (hold - 1) @(negedge clk_i);
      @(negedge clk_i) out_stall_i <= 1'b0;
    end
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic dedup_beat_t decl_beat(logic [1:0] kind);
    dedup_beat_t b;
    b      = '0;
    b.cmd  = kind;
    // Payload of a declaration means nothing; make it noise
    b.pos  = IN_IDX_W'($urandom);
    b.tex  = IN_IDX_W'($urandom);
    b.norm = IN_IDX_W'($urandom);
    return b;
  endfunction

  function automatic dedup_beat_t face_beat(logic [1:0] corner, logic [IN_IDX_W-1:0] p,
                                            logic [IN_IDX_W-1:0] t, logic [IN_IDX_W-1:0] n);
    dedup_beat_t b;
    b.cmd    = CMD_FACE;
    b.corner = corner;
    b.pos    = p;
    b.tex    = t;
    b.norm   = n;
    return b;
  endfunction

  // Favor the lowest few indices so triples repeat and the table gets hits
  function automatic logic [IN_IDX_W-1:0] pick_index(int unsigned count);
    if (count == 0) return IN_IDX_W'(1);
    if ($urandom_range(0, 9) < 6) return IN_IDX_W'($urandom_range(1, count < 4 ? count : 4));
    return IN_IDX_W'($urandom_range(1, count));
  endfunction

  function automatic logic [IN_IDX_W-1:0] noise_index(int unsigned count);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return IN_IDX_W'(count + 1);
      2: return IN_IDX_W'($urandom);
      default: return pick_index(count);
    endcase
  endfunction

  // Present one beat at the falling edge and hold it until taken
  task automatic drive_beat(input dedup_beat_t b, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    cmd_i         <= b.cmd;
    corner_form_i <= b.corner;
    pos_index_i   <= b.pos;
    tex_index_i   <= b.tex;
    norm_index_i  <= b.norm;
    do @(posedge clk_i); while (in_stall_o);
    if (b.cmd != CMD_FACE && declared[b.cmd] < MAX_ATTRIBUTES) declared[b.cmd]++;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.awaited_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    dedup_beat_t beat;
    int unsigned k;
    int unsigned sel;
    sb            = new();
    declared[0]   = 0;
    declared[1]   = 0;
    declared[2]   = 0;
    mesh_corner   = 2'($urandom_range(CORNER_V, CORNER_VTN));
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_POS;
    corner_form_i = CORNER_V;
    pos_index_i   = '0;
    tex_index_i   = '0;
    norm_index_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: lock the form on a corner that fails (nothing declared yet),
    // then refuse a corner of another form.
    drive_beat(face_beat(mesh_corner, 1, 1, 1), next_gap());
    drive_beat(face_beat(2'(mesh_corner + 2'd1), 1, 1, 1), next_gap());
    // Declare 3 positions, 2 texcoords, 2 normals
    drive_beat(decl_beat(CMD_POS), next_gap());
    drive_beat(decl_beat(CMD_POS), next_gap());
    drive_beat(decl_beat(CMD_POS), next_gap());
    drive_beat(decl_beat(CMD_TEX), next_gap());
    drive_beat(decl_beat(CMD_TEX), next_gap());
    drive_beat(decl_beat(CMD_NORM), next_gap());
    drive_beat(decl_beat(CMD_NORM), next_gap());
    // First miss, the same triple again as a hit, then the top of each count
    drive_beat(face_beat(mesh_corner, 1, 1, 1), next_gap());
    drive_beat(face_beat(mesh_corner, 1, 1, 1), next_gap());
    drive_beat(face_beat(mesh_corner, 3, 2, 2), next_gap());
    // Zero and one past the count in each component; an unused component
    // must be ignored, so these pass when the form lacks it.
    drive_beat(face_beat(mesh_corner, 0, 1, 1), next_gap());
    drive_beat(face_beat(mesh_corner, 4, 1, 1), next_gap());
    drive_beat(face_beat(mesh_corner, 2, 0, 1), next_gap());
    drive_beat(face_beat(mesh_corner, 2, 3, 1), next_gap());
    drive_beat(face_beat(mesh_corner, 2, 1, 0), next_gap());
    drive_beat(face_beat(mesh_corner, 2, 1, 3), next_gap());
    // The two remaining foreign forms
    drive_beat(face_beat(2'(mesh_corner + 2'd2), 1, 1, 1), next_gap());
    drive_beat(face_beat(2'(mesh_corner + 2'd3), 1, 1, 1), next_gap());
    // All ones in every index field
    drive_beat(face_beat(mesh_corner, '1, '1, '1), next_gap());
    // The block keeps going after errors: hit the second stored triple
    drive_beat(face_beat(mesh_corner, 3, 2, 2), next_gap());

    // Random: declarations grow the counts, well-formed corners with small
    // indices land hits and misses, and the rest is noise (foreign forms,
    // zero, one past the count, full-width junk).
    for (k = 0; k < RANDOM_BEATS; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30)
        beat = decl_beat(2'($urandom_range(CMD_POS, CMD_NORM)));
      else if (sel < 85)
        beat = face_beat(mesh_corner, pick_index(declared[CMD_POS]),
                         pick_index(declared[CMD_TEX]), pick_index(declared[CMD_NORM]));
      else
        beat = face_beat(2'($urandom_range(CORNER_V, CORNER_VTN)),
                         noise_index(declared[CMD_POS]), noise_index(declared[CMD_TEX]),
                         noise_index(declared[CMD_NORM]));
      drive_beat(beat, next_gap());
    end

    // Drain, then give a stray late result a full search time to show up
    wait_drained();
    repeat (SEARCH_CYCLES + 16) @(posedge clk_i);

    $display("Checked %0d new vertices, %0d hits, %0d form mismatches, %0d out of range,",
             sb.new_vertices, sb.status_tally[STATUS_OK] - sb.new_vertices,
             sb.status_tally[STATUS_MISMATCH], sb.status_tally[STATUS_RANGE]);
    $display("%0d table full, %0d count overflows; mesh corner form %0d, %0d mismatches",
             sb.status_tally[STATUS_FULL], sb.status_tally[STATUS_OVERFLOW], mesh_corner,
             sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest good run
  initial begin
    #400_000_000;
    $display("TIMEOUT: results still owed: %0d", sb.awaited_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
